// ===== design/sparse_feature_table_assert.svh =====
// assertion macros for the sparse feature table
`ifndef SPARSE_FEATURE_TABLE_ASSERT_SVH
`define SPARSE_FEATURE_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define SFT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define SFT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("%m failed");
`else
`define SFT_ASSERT(label, clk, rst_n, prop)
`define SFT_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== design/sft_pkg.sv =====
// ----------------------------------------------------------------------------
// sft_pkg
// types, constants and arithmetic helpers of the sparse feature table
// ----------------------------------------------------------------------------
package sft_pkg;
  localparam int unsigned CapacityDef  = 1024;
  localparam int unsigned IndexBitsDef = 24;
  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned OutIdxW = 24;
  localparam int unsigned CntW    = 11;

  typedef enum logic [2:0] {
    OpClear  = 3'd0,
    OpAdd    = 3'd1,
    OpLookup = 3'd2,
    OpScale  = 3'd3,
    OpPrune  = 3'd4,
    OpArgmax = 3'd5,
    OpNop6   = 3'd6,
    OpNop7   = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ModeDup     = 2'd0,
    ModeAcc     = 2'd1,
    ModeReplace = 2'd2,
    ModeKeep    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StIdle  = 2'd0,
    StRun   = 2'd1,
    StDrain = 2'd2,
    StOut   = 2'd3
  } state_e;

  // saturate a 34-bit sum to 32 bits
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    else if (v < -34'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction
endpackage

// ===== design/sft_cell.sv =====
// ----------------------------------------------------------------------------
// sft_cell
// one table slot: holds an entry and shifts it on to the next slot
// ----------------------------------------------------------------------------
module sft_cell #(
  parameter int unsigned IndexBits = sft_pkg::IndexBitsDef
) (
  input  logic                 clk_i,
  input  logic                 shift_i,
  input  logic [IndexBits-1:0] idx_i,
  input  logic [31:0]          val_i,
  output logic [IndexBits-1:0] idx_o,
  output logic [31:0]          val_o
);
  import sft_pkg::*;
  logic [IndexBits-1:0] idx_q;
  logic [31:0]          val_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      idx_q <= idx_i;
      val_q <= val_i;
    end
  end
  assign idx_o = idx_q;
  assign val_o = val_q;
endmodule

// ===== design/sft_proc.sv =====
// ----------------------------------------------------------------------------
// sft_proc
// entry processor at the head of the ring: multiply, compare, search
// ----------------------------------------------------------------------------
module sft_proc #(
  parameter int unsigned Capacity  = sft_pkg::CapacityDef,
  parameter int unsigned IndexBits = sft_pkg::IndexBitsDef,
  parameter int unsigned FracBits  = sft_pkg::FracBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 step_i,
  input  logic                 live_i,
  input  sft_pkg::op_e         op_i,
  input  sft_pkg::mode_e       mode_i,
  input  logic [IndexBits-1:0] key_i,
  input  logic signed [31:0]   val_i,
  input  logic signed [31:0]   scl_i,
  input  logic [32:0]          thr_i,
  input  logic [IndexBits-1:0] e_idx_i,
  input  logic signed [31:0]   e_val_i,
  output logic                 keep_o,
  output logic signed [31:0]   new_val_o,
  output logic                 hit_q_o,
  output logic signed [31:0]   rv_o,
  output logic [IndexBits-1:0] ri_o
);
  import sft_pkg::*;
  // wide enough to sum a full table of duplicates without wrapping
  localparam int unsigned AccW = 33 + $clog2(Capacity);

  logic hit_q;
  logic signed [AccW-1:0] acc_q;
  logic [IndexBits-1:0] ri_q;
  logic match, take;
  logic signed [63:0] prod;
  logic signed [63:0] pr;
  logic signed [63:0] q;
  logic [32:0] emag;

  function automatic logic signed [31:0] sat_acc(input logic signed [AccW-1:0] v);
    if (v[AccW-1:31] == '0 || v[AccW-1:31] == '1) return v[31:0];
    else if (v[AccW-1]) return 32'sh80000000;
    else return 32'sh7fffffff;
  endfunction

  assign match = live_i && (e_idx_i == key_i);
  assign prod  = 64'(e_val_i) * 64'(scl_i);
  always_comb begin
    pr = (FracBits > 0) ? prod + (64'sd1 <<< (FracBits - 1)) : prod;
    q  = pr >>> FracBits;   // floor after half-up bias gives ties toward +inf
  end
  assign emag = e_val_i[31] ? 33'(-34'(e_val_i)) : {1'b0, e_val_i};

  always_comb begin
    new_val_o = e_val_i;
    keep_o = 1'b1;
    take = 1'b0;
    case (op_i)
      OpAdd: begin
        if (match && !hit_q && mode_i != ModeDup) begin
          if (mode_i == ModeAcc) new_val_o = sat34(34'(e_val_i) + 34'(val_i));
          else if (mode_i == ModeReplace) new_val_o = val_i;
        end
      end
      OpScale: begin
        if (q > 64'sd2147483647) new_val_o = 32'sh7fffffff;
        else if (q < -64'sd2147483648) new_val_o = 32'sh80000000;
        else new_val_o = q[31:0];
      end
      OpPrune: keep_o = emag >= thr_i;
      OpArgmax: take = live_i && (!hit_q || AccW'(e_val_i) > acc_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      acc_q <= '0;
      ri_q  <= '0;
    end else if (start_i) begin
      hit_q <= 1'b0;
      acc_q <= '0;
      ri_q  <= '0;
    end else if (step_i) begin
      if (op_i == OpLookup && match) begin
        if (mode_i == ModeDup) acc_q <= acc_q + AccW'(e_val_i);
        else if (!hit_q) acc_q <= AccW'(e_val_i);
        hit_q <= 1'b1;
      end else if (op_i == OpAdd && match && mode_i != ModeDup) begin
        hit_q <= 1'b1;
      end else if (take) begin
        hit_q <= 1'b1;
        acc_q <= AccW'(e_val_i);
        ri_q  <= e_idx_i;
      end
    end
  end
  assign hit_q_o = hit_q;
  assign rv_o = sat_acc(acc_q);
  assign ri_o = ri_q;
endmodule

// ===== design/sparse_feature_table.sv =====
// an accepted add, lookup, scale, prune or argmax makes one ring rotation in the run state,
//   then the output state loads the result; clear and no-ops go straight to the output state
// throughput: one item in flight; the next item is taken the cycle after the result is accepted
// reset clears the count and state and sets the mode to add to existing; entry data needs no reset
// ----------------------------------------------------------------------------
// sparse_feature_table
// bounded sparse vector of (index, value) entries kept in a rotating ring of cells
// ----------------------------------------------------------------------------
module sparse_feature_table #(
  parameter int unsigned Capacity  = sft_pkg::CapacityDef,
  parameter int unsigned IndexBits = sft_pkg::IndexBitsDef,
  parameter int unsigned FracBits  = sft_pkg::FracBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode[2:0], feature_index[26:3], feature_value[58:27], scale_factor[90:59],
  // prune_threshold[122:91], zero fill
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_value[31:0], result_index[55:32], found[56], count_now[67:57],
  // overflow[68], zero fill
  output logic [71:0]  m_axis_tdata
);
  import sft_pkg::*;
  `include "sparse_feature_table_assert.svh"
  localparam int unsigned CW = $clog2(Capacity + 1);

  state_e state_q, state_d;
  mode_e  mode_q;
  op_e    op_q;
  logic [IndexBits-1:0] key_q;
  logic signed [31:0] val_q, scl_q;
  logic [32:0] thr_q;
  logic [CW-1:0] cnt_q, pos_q, wr_q, drop_q;
  logic out_v_q;
  logic [71:0] out_q, out_d;
  logic [IndexBits-1:0] idx_c [Capacity];
  logic [31:0]          val_c [Capacity];
  logic [IndexBits-1:0] head_idx;
  logic [31:0]          head_val;
  logic live, keep, hit, shift, start, drop;
  logic signed [31:0] new_val, rv;
  logic [IndexBits-1:0] ri;
  logic [IndexBits-1:0] in_idx;
  logic signed [31:0] in_thr;

  assign in_idx = IndexBits'(s_axis_tdata[26:3]);
  assign in_thr = s_axis_tdata[122:91];
  assign s_axis_tready = (state_q == StIdle) && !out_v_q;
  assign start = s_axis_tvalid && s_axis_tready;
  assign live  = pos_q < cnt_q;
  assign shift = (state_q == StRun);
  assign drop  = (op_q == OpPrune) && live && !keep;

  sft_proc #(.Capacity(Capacity), .IndexBits(IndexBits), .FracBits(FracBits)) u_proc (
    .clk_i, .rst_ni, .start_i(start), .step_i(shift), .live_i(live),
    .op_i(op_q), .mode_i(mode_q), .key_i(key_q), .val_i(val_q), .scl_i(scl_q),
    .thr_i(thr_q), .e_idx_i(idx_c[Capacity-1]), .e_val_i(val_c[Capacity-1]),
    .keep_o(keep), .new_val_o(new_val), .hit_q_o(hit), .rv_o(rv), .ri_o(ri)
  );

  // processed entry re-enters the ring; an append takes the free slot at the count
  always_comb begin
    head_idx = idx_c[Capacity-1];
    head_val = new_val;
    if (op_q == OpAdd && pos_q == cnt_q && !hit && cnt_q < CW'(Capacity)) begin
      head_idx = key_q;
      head_val = val_q;
    end
  end

  // the entry re-enters at the cell given by the drop count, which closes the gaps
  // left by pruned entries once the rotation completes
  for (genvar g = 0; g < Capacity; g++) begin : g_ring
    logic inj;
    assign inj = !drop && (drop_q == CW'(g));
    sft_cell #(.IndexBits(IndexBits)) u_cell (
      .clk_i, .shift_i(shift),
      .idx_i(inj ? head_idx : idx_c[(g == 0) ? Capacity-1 : g-1]),
      .val_i(inj ? head_val : val_c[(g == 0) ? Capacity-1 : g-1]),
      .idx_o(idx_c[g]), .val_o(val_c[g])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (start) begin
        if (op_e'(s_axis_tdata[2:0]) inside {OpClear, OpNop6, OpNop7}) state_d = StOut;
        else state_d = StRun;
      end
      StRun:   if (pos_q == CW'(Capacity - 1)) state_d = StOut;
      StDrain: state_d = StOut;
      StOut:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      mode_q  <= ModeAcc;
      cnt_q   <= '0;
      pos_q   <= '0;
      wr_q    <= '0;
      drop_q  <= '0;
      out_v_q <= 1'b0;
      op_q    <= OpNop7;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) mode_q <= mode_e'(cfg_wdata_i);
      if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
      if (start) begin
        op_q   <= op_e'(s_axis_tdata[2:0]);
        pos_q  <= '0;
        wr_q   <= '0;
        drop_q <= '0;
        if (op_e'(s_axis_tdata[2:0]) == OpClear) cnt_q <= '0;
      end
      if (shift) begin
        pos_q <= pos_q + 1'b1;
        if (live && keep) wr_q <= wr_q + 1'b1;
        if (drop) drop_q <= drop_q + 1'b1;
      end
      if (state_q == StOut) begin
        if (op_q == OpPrune) cnt_q <= wr_q;
        else if (op_q == OpAdd && !hit && cnt_q < CW'(Capacity)) cnt_q <= cnt_q + 1'b1;
        out_v_q <= 1'b1;
      end
    end
  end

  // count reported with the result: the value the count takes at the end of the item
  logic [10:0] cnt_out;
  always_comb begin
    cnt_out = 11'(cnt_q);
    if (op_q == OpPrune) cnt_out = 11'(wr_q);
    else if (op_q == OpAdd && !hit && cnt_q < CW'(Capacity)) cnt_out = 11'(cnt_q + 1'b1);
  end

  always_comb begin
    out_d = '0;
    out_d[67:57] = cnt_out;
    out_d[68] = (op_q == OpAdd) && !hit && (cnt_q >= CW'(Capacity));
    if (op_q == OpLookup || op_q == OpArgmax) begin
      out_d[31:0] = rv;
      out_d[56]   = hit;
    end
    if (op_q == OpArgmax) out_d[55:32] = 24'(ri);
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      key_q <= in_idx;
      val_q <= s_axis_tdata[58:27];
      scl_q <= s_axis_tdata[90:59];
      thr_q <= in_thr[31] ? 33'(-34'(in_thr)) : {1'b0, in_thr};
    end
    if (state_q == StOut) out_q <= out_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  `SFT_ASSERT(a_cnt_cap, clk_i, rst_ni, cnt_q <= CW'(Capacity))
  `SFT_ASSERT(a_no_take_busy, clk_i, rst_ni, !(s_axis_tready && state_q != StIdle))
  `SFT_ASSERT_NEXT(a_out_after, clk_i, rst_ni, state_q == StOut, out_v_q)
endmodule
